// File: src/tcf_pkg.sv
// tilt complementary filter package: widths, register indexes, atan table
// and saturation helper; no dependencies
package tcf_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int GAIN_W       = 24;
  localparam int WEIGHT_W     = 16;
  localparam int ANG_W        = 25;
  localparam int CFG_W        = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int TABLE_LEN    = 24;
  localparam int CXY_W        = 28;
  localparam int CACC_W       = 34;
  localparam int BLEND_W      = 30;
  localparam int SAT_W        = 48;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 16'd32768;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd32113;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd1309441;

  localparam logic signed [SAT_W-1:0] ANG_MAX = 48'sd16777215;
  localparam logic signed [SAT_W-1:0] ANG_MIN = -48'sd16777216;
  localparam logic signed [CACC_W-1:0] DEG90_Q24 = 34'sd1509949440;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_WEIGHT = 2'd0,
    REG_GYRO_GAIN    = 2'd1
  } cfg_reg_e;

  function automatic logic signed [CACC_W-1:0] atan_q24(input logic [4:0] idx);
    logic signed [CACC_W-1:0] r;
    unique case (idx)
      5'd0:  r = 34'sd754974720;
      5'd1:  r = 34'sd445687602;
      5'd2:  r = 34'sd235489088;
      5'd3:  r = 34'sd119537938;
      5'd4:  r = 34'sd60000934;
      5'd5:  r = 34'sd30029717;
      5'd6:  r = 34'sd15018523;
      5'd7:  r = 34'sd7509720;
      5'd8:  r = 34'sd3754917;
      5'd9:  r = 34'sd1877466;
      5'd10: r = 34'sd938734;
      5'd11: r = 34'sd469367;
      5'd12: r = 34'sd234684;
      5'd13: r = 34'sd117342;
      5'd14: r = 34'sd58671;
      5'd15: r = 34'sd29335;
      5'd16: r = 34'sd14668;
      5'd17: r = 34'sd7334;
      5'd18: r = 34'sd3667;
      5'd19: r = 34'sd1833;
      5'd20: r = 34'sd917;
      5'd21: r = 34'sd458;
      5'd22: r = 34'sd229;
      5'd23: r = 34'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [SAT_W-1:0] v);
    logic signed [ANG_W-1:0] r;
    if (v > ANG_MAX) begin
      r = ANG_MAX[ANG_W-1:0];
    end else if (v < ANG_MIN) begin
      r = ANG_MIN[ANG_W-1:0];
    end else begin
      r = v[ANG_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/tcf_ser_mul.sv
// shift-and-add multiplier, one multiplier bit per cycle
// signed multiplicand, unsigned multiplier; uses tcf_pkg
module tcf_ser_mul #(
  parameter int WA = 16,
  parameter int WB = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [WA-1:0]      a_i,
  input  logic [WB-1:0]             b_i,
  output logic                      busy_o,
  output logic signed [WA+WB-1:0]   prod_o
);
  import tcf_pkg::*;

  localparam int CW = $clog2(WB + 1);

  logic signed [WA+WB-1:0] mcand_q, prod_q;
  logic [WB-1:0]           mplier_q;
  logic [CW-1:0]           cnt_q;
  logic                    busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CW'(WB)) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= (WA+WB)'(a_i);
      mplier_q <= b_i;
      prod_q   <= '0;
    end else if (busy_q && cnt_q != CW'(WB)) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = prod_q;

endmodule

// File: src/tcf_cordic.sv
// vectoring cordic for atan2(y, z) in degrees, one rotation per cycle
// uses tcf_pkg atan table and saturation
module tcf_cordic #(
  parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tcf_pkg::SAMPLE_W-1:0] y_i,
  input  logic signed [tcf_pkg::SAMPLE_W-1:0] z_i,
  output logic                              busy_o,
  output logic signed [tcf_pkg::ANG_W-1:0]  angle_o
);
  import tcf_pkg::*;

  localparam logic [4:0] NSTEP = 5'((CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS);
  localparam int RS = 24 - ANGLE_FRAC_BITS;

  logic signed [CXY_W-1:0]  x_q, y_q, xs, ys;
  logic signed [CACC_W-1:0] acc_q, rnd;
  logic [4:0]               cnt_q;
  logic                     busy_q, zero_q;
  logic signed [ANG_W-1:0]  angle_q;

  assign xs  = CXY_W'(z_i) <<< 8;
  assign ys  = CXY_W'(y_i) <<< 8;
  assign rnd = (acc_q + (CACC_W'(1) <<< (RS - 1))) >>> RS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == NSTEP) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (z_i == '0) && (y_i == '0);
      if (xs < 0) begin
        if (ys >= 0) begin
          x_q   <= ys;
          y_q   <= -xs;
          acc_q <= DEG90_Q24;
        end else begin
          x_q   <= -ys;
          y_q   <= xs;
          acc_q <= -DEG90_Q24;
        end
      end else begin
        x_q   <= xs;
        y_q   <= ys;
        acc_q <= '0;
      end
    end else if (busy_q) begin
      if (cnt_q == NSTEP) begin
        angle_q <= zero_q ? '0 : sat_ang(SAT_W'(rnd));
      end else if (y_q >= 0) begin
        x_q   <= x_q + (y_q >>> cnt_q);
        y_q   <= y_q - (x_q >>> cnt_q);
        acc_q <= acc_q + atan_q24(cnt_q);
      end else begin
        x_q   <= x_q - (y_q >>> cnt_q);
        y_q   <= y_q + (x_q >>> cnt_q);
        acc_q <= acc_q - atan_q24(cnt_q);
      end
    end
  end

  assign busy_o  = busy_q;
  assign angle_o = angle_q;

endmodule

// File: src/imu_tilt_complementary_filter.sv
// tilt complementary filter top level: config registers, sequencer, output register
// uses tcf_pkg, tcf_cordic and tcf_ser_mul
//
// Usage: the input channel (in_valid_i / in_stall_o) takes one raw sample:
// accel_y_i, accel_z_i and gyro_x_i. The output channel (out_valid_o /
// out_stall_i) returns tilt_angle_o (filtered) and accel_angle_o, both degrees
// Q16. One result per sample.
// From the accepting edge to out_valid_o the steps are the bit-serial gyro
// multiply (one gain bit per cycle, the cordic runs in parallel with one
// rotation per cycle), the start of the blend, the two bit-serial blend
// multiplies (one weight bit per cycle), entry to the output state and the
// load of the output register. One item is in work at a time, so no new
// sample is accepted until the last result has been loaded into it.
// The output register holds a result while out_stall_i is high; the next item
// can be accepted while it waits, but its result is held back until the
// register is free.
// Reset clears the stored angle to zero, loads the default weight (0.98) and
// gyro gain, and empties the output register. Write the config port only
// while idle.
module imu_tilt_complementary_filter #(
  parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [tcf_pkg::SAMPLE_W-1:0]  accel_y_i,
  input  logic signed [tcf_pkg::SAMPLE_W-1:0]  accel_z_i,
  input  logic signed [tcf_pkg::SAMPLE_W-1:0]  gyro_x_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [tcf_pkg::ANG_W-1:0]     tilt_angle_o,
  output logic signed [tcf_pkg::ANG_W-1:0]     accel_angle_o,
  input  logic                                 cfg_we_i,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [tcf_pkg::CFG_W-1:0]            cfg_wdata_i
);
  import tcf_pkg::*;

  localparam int GS    = 32 - ANGLE_FRAC_BITS;
  localparam int GP_W  = SAMPLE_W + GAIN_W;
  localparam int BP_W  = BLEND_W + WEIGHT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_BLEND,
    ST_OUT
  } state_e;

  state_e                   state_q;
  logic [WEIGHT_W-1:0]      weight_q, wa, wb;
  logic [GAIN_W-1:0]        gain_q;
  logic signed [ANG_W-1:0]  filt_q, accel_q, cordic_ang, blend_res;
  logic                     out_valid_q, in_acc, blend_start, out_load;
  logic                     cordic_busy, gmul_busy, bmul_a_busy, bmul_b_busy;
  logic signed [GP_W-1:0]   gprod;
  logic signed [GP_W:0]     inc_full;
  logic signed [BLEND_W-1:0] sum_op;
  logic signed [BP_W-1:0]   bprod_a, bprod_b;
  logic signed [BP_W:0]     bsum, brnd;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign wa       = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
  assign wb       = WEIGHT_ONE - wa;
  assign inc_full = ((GP_W+1)'(gprod) + ((GP_W+1)'(1) <<< (GS - 1))) >>> GS;
  assign sum_op   = BLEND_W'(filt_q) + inc_full[BLEND_W-1:0];
  assign blend_start = (state_q == ST_CALC) && !cordic_busy && !gmul_busy;
  assign bsum     = (BP_W+1)'(bprod_a) + (BP_W+1)'(bprod_b);
  assign brnd     = (bsum + (BP_W+1)'(16384)) >>> 15;
  assign blend_res = sat_ang(SAT_W'(brnd));
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  tcf_cordic #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .y_i     (accel_y_i),
    .z_i     (accel_z_i),
    .busy_o  (cordic_busy),
    .angle_o (cordic_ang)
  );

  tcf_ser_mul #(.WA(SAMPLE_W), .WB(GAIN_W)) u_gyro_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .a_i     (gyro_x_i),
    .b_i     (gain_q),
    .busy_o  (gmul_busy),
    .prod_o  (gprod)
  );

  tcf_ser_mul #(.WA(BLEND_W), .WB(WEIGHT_W)) u_blend_gyro (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (blend_start),
    .a_i     (sum_op),
    .b_i     (wa),
    .busy_o  (bmul_a_busy),
    .prod_o  (bprod_a)
  );

  tcf_ser_mul #(.WA(BLEND_W), .WB(WEIGHT_W)) u_blend_accel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (blend_start),
    .a_i     (BLEND_W'(cordic_ang)),
    .b_i     (wb),
    .busy_o  (bmul_b_busy),
    .prod_o  (bprod_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      weight_q    <= WEIGHT_RESET;
      gain_q      <= GAIN_RESET;
      filt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BLEND_WEIGHT: weight_q <= cfg_wdata_i[WEIGHT_W-1:0];
          REG_GYRO_GAIN:    gain_q   <= cfg_wdata_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (blend_start) begin
            state_q <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          if (!bmul_a_busy && !bmul_b_busy) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            filt_q      <= blend_res;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      accel_q <= cordic_ang;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign tilt_angle_o  = filt_q;
  assign accel_angle_o = accel_q;

endmodule

// File: src/tcf_checker.sv
// port-level checks for the tilt complementary filter, bound to the top level
// uses tcf_pkg widths
module tcf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [tcf_pkg::ANG_W-1:0]    tilt_angle_o,
  input logic signed [tcf_pkg::ANG_W-1:0]    accel_angle_o
);
  import tcf_pkg::*;

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result lands as the sequencer goes idle
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result shown while still busy");

  // accelerometer tilt stays within the reach of the cordic angle sum
  a_accel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accel_angle_o <= 25'sd12451840 && accel_angle_o >= -25'sd12451840))
    else $error("accel angle out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(tilt_angle_o)
      && $stable(accel_angle_o)))
    else $error("stalled result changed");

endmodule

bind imu_tilt_complementary_filter tcf_checker u_tcf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .tilt_angle_o  (tilt_angle_o),
  .accel_angle_o (accel_angle_o)
);
